FILE: hw/rtl/ffpa_pkg.sv
package ffpa_pkg;

    // widths of the request and result fields
    localparam int OPERATION_W = 1;
    localparam int ORDER_W     = 4;
    localparam int FRAME_W     = 10;
    localparam int FIRST_W     = 10;
    localparam int FREE_W      = 11;
    localparam int LIMIT_W     = 11;
    localparam int COUNT_W     = 8;

    // operation codes
    localparam logic [OPERATION_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OPERATION_W-1:0] OP_FREE  = 1'b1;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_IDLE    = 6'b000010,
        ST_RECOUNT = 6'b000100,
        ST_SCAN    = 6'b001000,
        ST_FILL    = 6'b010000,
        ST_FREE    = 6'b100000
    } t_state;

endpackage

FILE: hw/rtl/ffpa_ram.sv
module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/first_fit_page_run_allocator.sv
// allocate: scan from page zero to the end of the first free run, then fill the run; no
//   space: scan to the limit, then fail; free: update each page of the run; bad order or run: fail
// throughput: one request at a time, busy high until the result strobe; the next request can
//   be taken in the strobe cycle. one page per cycle through the count memory
// reset: synchronous clearing pass over all NUM_PAGES counts, busy high; a usable_pages write
//   keeps busy high through a recount below the new limit; o_done cannot be stalled
module first_fit_page_run_allocator #(
    parameter int NUM_PAGES = 1024,
    parameter int MAX_ORDER = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request side
    input  logic                              start,
    output logic                              busy,
    input  logic [ffpa_pkg::OPERATION_W-1:0]  i_operation,
    input  logic [ffpa_pkg::ORDER_W-1:0]      i_order,
    input  logic [ffpa_pkg::FRAME_W-1:0]      i_frame,
    // usable page limit register
    input  logic                              i_cfg_we,
    input  logic [ffpa_pkg::LIMIT_W-1:0]      i_cfg_wdata,
    // result side
    output logic                              o_done,
    output logic                              o_ok,
    output logic [ffpa_pkg::FIRST_W-1:0]      o_first_page,
    output logic [ffpa_pkg::FREE_W-1:0]       o_free_pages
);

    // page index width, and a common width for indexes, limits and run lengths
    localparam int PW  = $clog2(NUM_PAGES);
    localparam int XW0 = (PW + 1 > ffpa_pkg::LIMIT_W) ? PW + 1 : ffpa_pkg::LIMIT_W;
    localparam int XW  = (XW0 > MAX_ORDER + 1) ? XW0 : MAX_ORDER + 1;
    localparam int CW  = ffpa_pkg::COUNT_W;

    ffpa_pkg::t_state r_state, n_state;

    logic [XW-1:0]                 r_idx, n_idx;     // next page to read or write
    logic [XW-1:0]                 r_end, n_end;     // sweep end (exclusive), fill end (inclusive)
    logic [XW-1:0]                 r_pidx, n_pidx;   // page whose count arrives this cycle
    logic                          r_pv, n_pv;       // read data valid
    logic [XW-1:0]                 r_run, n_run;     // length of current zero run
    logic [XW-1:0]                 r_len, n_len;     // requested run length
    logic [XW-1:0]                 r_lim, n_lim;     // effective page limit
    logic                          r_pend, n_pend;   // recount owed after a limit write
    logic [ffpa_pkg::FREE_W-1:0]   r_free, n_free;
    logic                          r_done, n_done;
    logic                          r_ok, n_ok;
    logic [XW-1:0]                 r_first, n_first;

    // count memory port
    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [CW-1:0] ram_wdata;
    logic [CW-1:0] ram_rdata;

    logic [XW-1:0] cfg_lim;
    logic [XW-1:0] req_len;
    logic [XW:0]   free_top;
    logic          issue;
    logic          sweep_end;
    logic          rd_zero;
    logic [XW-1:0] run_nx;

    ffpa_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_PAGES)
    ) u_usage (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[PW-1:0]),
        .o_rdata (ram_rdata)
    );

    // new limit clamped to the number of pages present
    always_comb begin
        if (XW'(i_cfg_wdata) > XW'(NUM_PAGES)) begin
            cfg_lim = XW'(NUM_PAGES);
        end else begin
            cfg_lim = XW'(i_cfg_wdata);
        end
    end

    assign req_len   = XW'(1) << i_order;
    assign free_top  = {1'b0, XW'(i_frame)} + {1'b0, req_len};
    assign issue     = (r_idx < r_end);
    assign sweep_end = !r_pv && !issue;
    assign rd_zero   = (ram_rdata == '0);
    assign run_nx    = rd_zero ? (r_run + XW'(1)) : '0;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_end     = r_end;
        n_pidx    = r_idx;
        n_pv      = 1'b0;
        n_run     = r_run;
        n_len     = r_len;
        n_lim     = r_lim;
        n_pend    = r_pend;
        n_free    = r_free;
        n_done    = 1'b0;
        n_ok      = r_ok;
        n_first   = r_first;
        ram_we    = 1'b0;
        ram_waddr = r_pidx[PW-1:0];
        ram_wdata = '0;

        case (r_state)
            ffpa_pkg::ST_CLEAR: begin
                // zero one count per cycle, then every usable page is free
                ram_we    = 1'b1;
                ram_waddr = r_idx[PW-1:0];
                if (r_idx == XW'(NUM_PAGES - 1)) begin
                    n_state = ffpa_pkg::ST_IDLE;
                    n_idx   = '0;
                    n_free  = i_cfg_we ? ffpa_pkg::FREE_W'(cfg_lim)
                                       : ffpa_pkg::FREE_W'(r_lim);
                end else begin
                    n_idx = r_idx + XW'(1);
                end
            end

            ffpa_pkg::ST_IDLE: begin
                if (r_pend) begin
                    // count zero counts below the new limit
                    n_state = ffpa_pkg::ST_RECOUNT;
                    n_pend  = 1'b0;
                    n_idx   = '0;
                    n_end   = r_lim;
                    n_free  = '0;
                end else if (start) begin
                    n_first = '0;
                    n_run   = '0;
                    n_len   = req_len;
                    if (int'(i_order) > MAX_ORDER) begin
                        // order out of range: fail at once, nothing changes
                        n_done = 1'b1;
                        n_ok   = 1'b0;
                    end else if (i_operation == ffpa_pkg::OP_ALLOC) begin
                        n_state = ffpa_pkg::ST_SCAN;
                        n_idx   = '0;
                        n_end   = r_lim;
                    end else if (free_top <= {1'b0, r_lim}) begin
                        n_state = ffpa_pkg::ST_FREE;
                        n_idx   = XW'(i_frame);
                        n_end   = free_top[XW-1:0];
                        n_ok    = 1'b1;
                    end else begin
                        // run passes the limit
                        n_done = 1'b1;
                        n_ok   = 1'b0;
                    end
                end
            end

            ffpa_pkg::ST_RECOUNT: begin
                n_pv  = issue;
                n_idx = r_idx + XW'(issue);
                if (r_pv && rd_zero) begin
                    n_free = r_free + ffpa_pkg::FREE_W'(1);
                end
                if (sweep_end) begin
                    n_state = ffpa_pkg::ST_IDLE;
                end
            end

            ffpa_pkg::ST_SCAN: begin
                if (r_pv && (run_nx == r_len)) begin
                    // first free run found, ends at the page just read
                    n_state = ffpa_pkg::ST_FILL;
                    n_first = r_pidx + XW'(1) - r_len;
                    n_idx   = r_pidx + XW'(1) - r_len;
                    n_end   = r_pidx;
                    if (XW'(r_free) >= r_len) begin
                        n_free = r_free - ffpa_pkg::FREE_W'(r_len);
                    end else begin
                        n_free = '0;
                    end
                end else begin
                    if (r_pv) begin
                        n_run = run_nx;
                    end
                    n_pv  = issue;
                    n_idx = r_idx + XW'(issue);
                    if (sweep_end) begin
                        // no space below the limit
                        n_state = ffpa_pkg::ST_IDLE;
                        n_done  = 1'b1;
                        n_ok    = 1'b0;
                        n_first = '0;
                    end
                end
            end

            ffpa_pkg::ST_FILL: begin
                // every page of the run was zero, so each count becomes one
                ram_we    = 1'b1;
                ram_waddr = r_idx[PW-1:0];
                ram_wdata = CW'(1);
                if (r_idx == r_end) begin
                    n_state = ffpa_pkg::ST_IDLE;
                    n_done  = 1'b1;
                    n_ok    = 1'b1;
                end else begin
                    n_idx = r_idx + XW'(1);
                end
            end

            ffpa_pkg::ST_FREE: begin
                // read one page ahead, write back the decremented count behind
                if (r_pv) begin
                    if (rd_zero) begin
                        n_ok = 1'b0;
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata - CW'(1);
                        if (ram_rdata == CW'(1)) begin
                            n_free = r_free + ffpa_pkg::FREE_W'(1);
                        end
                    end
                end
                n_pv  = issue;
                n_idx = r_idx + XW'(issue);
                if (sweep_end) begin
                    n_state = ffpa_pkg::ST_IDLE;
                    n_done  = 1'b1;
                end
            end

            default: begin
                n_state = ffpa_pkg::ST_IDLE;
            end
        endcase

        // limit write; the clearing pass picks the new limit up at its end
        if (i_cfg_we) begin
            n_lim = cfg_lim;
            if (r_state != ffpa_pkg::ST_CLEAR) begin
                n_pend = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffpa_pkg::ST_CLEAR;
            r_idx   <= '0;
            r_pv    <= 1'b0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
            r_free  <= '0;
            r_lim   <= (NUM_PAGES < 1024) ? XW'(NUM_PAGES) : XW'(1024);
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pv    <= n_pv;
            r_pend  <= n_pend;
            r_done  <= n_done;
            r_free  <= n_free;
            r_lim   <= n_lim;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_end   <= n_end;
        r_pidx  <= n_pidx;
        r_run   <= n_run;
        r_len   <= n_len;
        r_ok    <= n_ok;
        r_first <= n_first;
    end

    assign busy         = (r_state != ffpa_pkg::ST_IDLE) || r_pend;
    assign o_done       = r_done;
    assign o_ok         = r_ok;
    assign o_first_page = r_first[ffpa_pkg::FIRST_W-1:0];
    assign o_free_pages = r_free;

    // no result while the count memory is still being cleared
    a_no_done_in_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffpa_pkg::ST_CLEAR) |-> !o_done)
        else $error("result strobe during clearing pass");

    // failed requests report page zero
    a_fail_first_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_ok) |-> (o_first_page == '0))
        else $error("failed request with non-zero first page");

    // fill pass never runs past the end of the found run
    a_fill_in_run : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffpa_pkg::ST_FILL) |-> (r_idx <= r_end))
        else $error("fill pass beyond found run");

    // a strobe only ever comes while the sequencer is idle
    a_done_at_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == ffpa_pkg::ST_IDLE))
        else $error("result strobe outside idle");

endmodule

FILE: verif/tb_first_fit_page_run_allocator.sv
`timescale 1ns / 100ps

module tb_first_fit_page_run_allocator;

    localparam int NUM_PAGES       = 1024;
    localparam int MAX_ORDER       = 10;
    localparam int RANDOM_REQUESTS = 1050;
    localparam int PHASE_REQUESTS  = 150;
    // worst request is an order 10 allocate, longer than the clearing pass
    localparam int STALL_LIMIT     = 20000;
    localparam int DRAIN_CYCLES    = 2100;

    typedef struct packed {
        logic                          ok;
        logic [ffpa_pkg::FIRST_W-1:0]  first_page;
        logic [ffpa_pkg::FREE_W-1:0]   free_pages;
    } t_page_result;

    typedef struct packed {
        logic [ffpa_pkg::FIRST_W-1:0]  first_page;
        logic [ffpa_pkg::ORDER_W-1:0]  order;
    } t_page_run;

    typedef enum logic {
        STEP_REQUEST,
        STEP_LIMIT
    } t_step_kind;

    typedef struct packed {
        t_step_kind                        kind;
        logic [ffpa_pkg::OPERATION_W-1:0]  operation;
        logic [ffpa_pkg::ORDER_W-1:0]      order;
        logic [ffpa_pkg::FRAME_W-1:0]      frame;
        logic [ffpa_pkg::LIMIT_W-1:0]      limit;
        logic                              typed;
        t_page_result                      want;
    } t_plan_step;

    // block ports, inputs all known from time zero
    logic                              i_clk        = 1'b0;
    logic                              i_rst_n      = 1'b0;
    logic                              start        = 1'b0;
    logic                              busy;
    logic [ffpa_pkg::OPERATION_W-1:0]  i_operation  = ffpa_pkg::OP_ALLOC;
    logic [ffpa_pkg::ORDER_W-1:0]      i_order      = '0;
    logic [ffpa_pkg::FRAME_W-1:0]      i_frame      = '0;
    logic                              i_cfg_we     = 1'b0;
    logic [ffpa_pkg::LIMIT_W-1:0]      i_cfg_wdata  = '0;
    logic                              o_done;
    logic                              o_ok;
    logic [ffpa_pkg::FIRST_W-1:0]      o_first_page;
    logic [ffpa_pkg::FREE_W-1:0]       o_free_pages;

    // predictor state: per-page usage counts, usable page limit, free total
    logic [ffpa_pkg::COUNT_W-1:0]  page_count [NUM_PAGES];
    logic [ffpa_pkg::LIMIT_W-1:0]  usable_pages_reg;
    int                            free_count;

    t_page_result  awaited_results [$];
    t_page_run     live_runs [$];
    t_plan_step    directed_plan [$];

    int  mismatches  = 0;
    int  idle_cycles = 0;
    int  sent        = 0;
    bit  no_gaps     = 1'b0;

    always #1 i_clk = ~i_clk;

    first_fit_page_run_allocator #(
        .NUM_PAGES (NUM_PAGES),
        .MAX_ORDER (MAX_ORDER)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_order      (i_order),
        .i_frame      (i_frame),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_done       (o_done),
        .o_ok         (o_ok),
        .o_first_page (o_first_page),
        .o_free_pages (o_free_pages)
    );

    // limits above the page count are clipped to it
    function automatic int page_limit();
        return (usable_pages_reg > NUM_PAGES) ? NUM_PAGES : int'(usable_pages_reg);
    endfunction

    // new limit: free total is recounted over the pages below it
    function automatic void set_usable_pages(input logic [ffpa_pkg::LIMIT_W-1:0] value);
        int n;
        n = 0;
        usable_pages_reg = value;
        for (int i = 0; i < page_limit(); i++)
            if (page_count[i] == '0)
                n++;
        free_count = n;
    endfunction

    // first-fit allocate or run free, updating the predicted counts
    function automatic t_page_result apply_page_request(
            input logic [ffpa_pkg::OPERATION_W-1:0] op,
            input logic [ffpa_pkg::ORDER_W-1:0] ord,
            input logic [ffpa_pkg::FRAME_W-1:0] frm);
        t_page_result r;
        int lim, len, run, first, f;
        r     = '0;
        lim   = page_limit();
        f     = int'(frm);
        if (ord <= MAX_ORDER) begin
            len = 1 << ord;
            if (op == ffpa_pkg::OP_ALLOC) begin
                run = 0;
                for (int i = 0; i < lim; i++) begin
                    run = (page_count[i] == '0) ? run + 1 : 0;
                    if (run == len) begin
                        first = i + 1 - len;
                        for (int k = first; k <= i; k++)
                            if (page_count[k] != '1)
                                page_count[k]++;
                        free_count   = (free_count >= len) ? free_count - len : 0;
                        r.ok         = 1'b1;
                        r.first_page = first[ffpa_pkg::FIRST_W-1:0];
                        break;
                    end
                end
            end else if (f + len <= lim) begin
                r.ok = 1'b1;
                for (int i = f; i < f + len; i++) begin
                    // a page already free stays free and spoils the whole request
                    if (page_count[i] == '0) begin
                        r.ok = 1'b0;
                    end else begin
                        page_count[i]--;
                        if (page_count[i] == '0)
                            free_count++;
                    end
                end
            end
        end
        r.free_pages = free_count[ffpa_pkg::FREE_W-1:0];
        return r;
    endfunction

    function automatic void plan_request(input logic [ffpa_pkg::OPERATION_W-1:0] op,
                                         input int ord,
                                         input int frm, input bit typed = 1'b0,
                                         input bit ok = 1'b0, input int first = 0,
                                         input int free_left = 0);
        t_plan_step step;
        step                 = '0;
        step.kind            = STEP_REQUEST;
        step.operation       = op;
        step.order           = ord[ffpa_pkg::ORDER_W-1:0];
        step.frame           = frm[ffpa_pkg::FRAME_W-1:0];
        step.typed           = typed;
        step.want.ok         = ok;
        step.want.first_page = first[ffpa_pkg::FIRST_W-1:0];
        step.want.free_pages = free_left[ffpa_pkg::FREE_W-1:0];
        directed_plan.push_back(step);
    endfunction

    function automatic void plan_limit(input int value);
        t_plan_step step;
        step       = '0;
        step.kind  = STEP_LIMIT;
        step.limit = value[ffpa_pkg::LIMIT_W-1:0];
        directed_plan.push_back(step);
    endfunction

    // present one request after a random gap and hold it until busy drops
    task automatic send_request(input logic [ffpa_pkg::OPERATION_W-1:0] op,
                                input logic [ffpa_pkg::ORDER_W-1:0] ord,
                                input logic [ffpa_pkg::FRAME_W-1:0] frm,
                                input bit typed, input t_page_result want,
                                output t_page_result res);
        int gap;
        // every sixteen requests, sometimes a stretch with no gaps at all
        if (sent % 16 == 0)
            no_gaps = ($urandom_range(0, 3) == 0);
        sent++;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_operation <= op;
        i_order     <= ord;
        i_frame     <= frm;
        start       <= 1'b1;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        // taken at this edge: start is either lowered or reloaded by the caller now
        res = apply_page_request(op, ord, frm);
        awaited_results.push_back(typed ? want : res);
    endtask

    // limit write only once the block has drained and gone idle
    task automatic write_limit(input logic [ffpa_pkg::LIMIT_W-1:0] value);
        start <= 1'b0;
        while (awaited_results.size() != 0 || busy !== 1'b0)
            @(posedge i_clk);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        set_usable_pages(value);
    endtask

    // result checker: each strobe against the oldest awaited result
    always @(posedge i_clk) begin
        t_page_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: result with none awaited: ok %0d first_page %0d free_pages %0d",
                         $time, o_ok, o_first_page, o_free_pages);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                if (o_ok !== want.ok) begin
                    $display("%0t: ok expected %0d actual %0d", $time, want.ok, o_ok);
                    mismatches++;
                end
                if (o_first_page !== want.first_page) begin
                    $display("%0t: first_page expected %0d actual %0d",
                             $time, want.first_page, o_first_page);
                    mismatches++;
                end
                if (o_free_pages !== want.free_pages) begin
                    $display("%0t: free_pages expected %0d actual %0d",
                             $time, want.free_pages, o_free_pages);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no request, result or limit write
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1 || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL first_fit_page_run_allocator");
            $finish;
        end
    end

    initial begin
        t_plan_step                        step;
        t_page_result                      res;
        t_page_run                         run;
        int                                r, s, idx, random_sent;
        logic [ffpa_pkg::OPERATION_W-1:0]  op;
        logic [ffpa_pkg::ORDER_W-1:0]      ord;
        logic [ffpa_pkg::FRAME_W-1:0]      frm;
        logic [ffpa_pkg::LIMIT_W-1:0]      limit_value;

        // predictor out of reset: every page free, full limit
        foreach (page_count[i])
            page_count[i] = '0;
        set_usable_pages(ffpa_pkg::LIMIT_W'(1024));

        // directed requests, typed results where they are obvious
        plan_request(ffpa_pkg::OP_ALLOC, 0, 0, 1, 1, 0, 1023);     // lowest page goes first
        plan_request(ffpa_pkg::OP_ALLOC, 10, 1023, 1, 0, 0, 1023); // full range no longer free
        plan_request(ffpa_pkg::OP_ALLOC, 11, 0, 1, 0, 0, 1023);    // order above the maximum
        plan_request(ffpa_pkg::OP_FREE, 15, 0, 1, 0, 0, 1023);     // bad order on free
        plan_request(ffpa_pkg::OP_FREE, 0, 0, 1, 1, 0, 1024);
        plan_request(ffpa_pkg::OP_FREE, 0, 0, 1, 0, 0, 1024);      // double free
        plan_request(ffpa_pkg::OP_ALLOC, 10, 0, 1, 1, 0, 0);       // whole range in one run
        plan_request(ffpa_pkg::OP_ALLOC, 0, 0, 1, 0, 0, 0);        // no space left
        plan_request(ffpa_pkg::OP_FREE, 1, 1023, 1, 0, 0, 0);      // run crosses the limit
        plan_request(ffpa_pkg::OP_FREE, 9, 512, 1, 1, 0, 512);
        plan_request(ffpa_pkg::OP_FREE, 10, 0, 1, 0, 0, 1024);     // upper half already free
        plan_request(ffpa_pkg::OP_FREE, 0, 1023, 1, 0, 0, 1024);
        plan_limit(1);
        plan_request(ffpa_pkg::OP_ALLOC, 0, 1023, 1, 1, 0, 0);
        plan_request(ffpa_pkg::OP_ALLOC, 0, 0, 1, 0, 0, 0);
        plan_request(ffpa_pkg::OP_FREE, 1, 0, 1, 0, 0, 0);         // two-page run crosses the limit
        plan_request(ffpa_pkg::OP_FREE, 0, 0, 1, 1, 0, 1);
        plan_limit(0);                                             // nothing usable
        plan_request(ffpa_pkg::OP_ALLOC, 0, 0, 1, 0, 0, 0);
        plan_request(ffpa_pkg::OP_FREE, 0, 0, 1, 0, 0, 0);
        plan_limit(2047);                                          // clipped to the page count
        plan_request(ffpa_pkg::OP_ALLOC, 3, 682, 1, 1, 0, 1016);   // frame ignored on allocate
        plan_request(ffpa_pkg::OP_ALLOC, 2, 341, 1, 1, 8, 1012);
        plan_request(ffpa_pkg::OP_FREE, 3, 0, 1, 1, 0, 1020);
        plan_request(ffpa_pkg::OP_ALLOC, 1, 0);                    // refills the hole
        plan_request(ffpa_pkg::OP_ALLOC, 2, 0);
        plan_request(ffpa_pkg::OP_FREE, 0, 9);                     // one page out of a live run
        plan_request(ffpa_pkg::OP_ALLOC, 0, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[n]) begin
            step = directed_plan[n];
            if (step.kind == STEP_LIMIT)
                write_limit(step.limit);
            else
                send_request(step.operation, step.order, step.frame, step.typed, step.want,
                             res);
        end

        // random part: mostly allocate and free of live runs, some noise
        random_sent = 0;
        while (random_sent < RANDOM_REQUESTS) begin
            if (random_sent % PHASE_REQUESTS == 0) begin
                case (random_sent / PHASE_REQUESTS)
                    0:       limit_value = ffpa_pkg::LIMIT_W'(1024);
                    1:       limit_value = ffpa_pkg::LIMIT_W'($urandom_range(1, 48));
                    2:       limit_value = ffpa_pkg::LIMIT_W'(2047);
                    3:       limit_value = ffpa_pkg::LIMIT_W'($urandom_range(200, 1023));
                    4:       limit_value = ffpa_pkg::LIMIT_W'($urandom_range(1025, 2047));
                    5:       limit_value = ffpa_pkg::LIMIT_W'($urandom_range(1, 1024));
                    default: limit_value = ffpa_pkg::LIMIT_W'(1024);
                endcase
                write_limit(limit_value);
            end
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // noise: any operation, order and frame, bad ones included
                op  = ffpa_pkg::OPERATION_W'($urandom_range(0, 1));
                ord = ffpa_pkg::ORDER_W'($urandom_range(0, 15));
                frm = ffpa_pkg::FRAME_W'($urandom_range(0, 1023));
            end else if (live_runs.size() > 0 && (r < 52 || free_count < 48)) begin
                idx = $urandom_range(0, live_runs.size() - 1);
                run = live_runs[idx];
                live_runs.delete(idx);
                op  = ffpa_pkg::OP_FREE;
                ord = run.order;
                frm = run.first_page;
            end else begin
                // small runs mostly, the odd large one
                s   = $urandom_range(0, 99);
                op  = ffpa_pkg::OP_ALLOC;
                ord = ffpa_pkg::ORDER_W'((s < 70) ? $urandom_range(0, 2) :
                                         (s < 95) ? $urandom_range(3, 5) :
                                         (s < 99) ? $urandom_range(6, 9) : MAX_ORDER);
                frm = ffpa_pkg::FRAME_W'($urandom_range(0, 1023));
            end
            send_request(op, ord, frm, 1'b0, '0, res);
            if (op == ffpa_pkg::OP_ALLOC && res.ok) begin
                run.first_page = res.first_page;
                run.order      = ord;
                live_runs.push_back(run);
            end
            random_sent++;
        end

        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        // room for a stray strobe after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS first_fit_page_run_allocator");
        else
            $display("FAIL first_fit_page_run_allocator");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ffpa_pkg.sv
hw/rtl/ffpa_ram.sv
hw/rtl/first_fit_page_run_allocator.sv
verif/tb_first_fit_page_run_allocator.sv
